// File: rtl/asdc_pkg.sv
// ----------------------------------------------------------------------------
// asdc_pkg
// Types and constants for the swing direction classifier.
// ----------------------------------------------------------------------------
package asdc_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int DIFF_W       = 17;
    localparam int THRESH_W     = 16;
    localparam int WINDOW_W     = 8;
    localparam int INDEX_W      = 9;
    localparam int DIR_W        = 2;
    localparam int CAT_W        = 8;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 32;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam int MAX_WINDOW_DEF = 255;
    localparam int WINDOW_LIMIT   = 255;

    localparam logic [THRESH_W-1:0] THRESHOLD_RST = 16'd4915;
    localparam logic [WINDOW_W-1:0] WINDOW_RST    = 8'd75;

    // Position marker meaning "no peak recorded"
    localparam logic [INDEX_W-1:0] NO_INDEX = '1;

    // Register index (paddr[2])
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_WINDOW    = 1'b1;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_STANDING = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FORWARD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BACKWARD = 2'd2;

    // Reward categories
    localparam logic signed [CAT_W-1:0] CAT_STANDING = 8'sd0;
    localparam logic signed [CAT_W-1:0] CAT_FORWARD  = 8'sd100;
    localparam logic signed [CAT_W-1:0] CAT_BACKWARD = -8'sd100;

    typedef struct packed {
        logic signed [DIFF_W-1:0] peak_value;
        logic signed [CAT_W-1:0]  category;
        logic [DIR_W-1:0]         direction;
    } result_t;

endpackage

// File: rtl/accel_swing_direction_classifier.sv
// ----------------------------------------------------------------------------
// accel_swing_direction_classifier
// Baseline-relative peak tracking over a window of X acceleration samples.
// ----------------------------------------------------------------------------
// The block takes one accelerometer X sample per cycle on the s_ stream. The
// first sample of a run is the baseline; each of the next window_samples
// samples (0 acts as 1, capped at MAX_WINDOW and at 255) is compared against
// it, and the run ends with one result item: standing, forward (minimum came
// first) or backward, with the winning peak. Each sample passes an input
// register and updates the run state as it leaves it, so the result of a run
// is loaded into the result register by the last sample of that run. The rate
// is one item per cycle, set by the combinational subtract and compare and the
// update of the peak registers; it drops only while the result register is
// held by m_tready low. Registers: threshold at byte address 0, window_samples at 4.
module accel_swing_direction_classifier
    import asdc_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // APB configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready,
    // sample stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_TDATA_W-1:0]   s_tdata,   // [15:0] accel_x
    // result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_TDATA_W-1:0]  m_tdata    // [1:0] direction, [9:2] category,
                                               // [26:10] peak_value, [31:27] zero
);

    localparam int EFF_MAX = (MAX_WINDOW > WINDOW_LIMIT) ? WINDOW_LIMIT : MAX_WINDOW;
    localparam int CNT_W   = (EFF_MAX < 2) ? 1 : $clog2(EFF_MAX + 1);
    localparam logic [WINDOW_W-1:0] EFF_MAX_W = WINDOW_W'(EFF_MAX);

    // ---------------- configuration ----------------
    logic [THRESH_W-1:0] threshold_reg;
    logic [WINDOW_W-1:0] window_reg;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RST;
            window_reg    <= WINDOW_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_THRESHOLD: threshold_reg <= pwdata[THRESH_W-1:0];
                default:       window_reg    <= pwdata[WINDOW_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_THRESHOLD: prdata = {{(APB_DATA_W-THRESH_W){1'b0}}, threshold_reg};
            default:       prdata = {{(APB_DATA_W-WINDOW_W){1'b0}}, window_reg};
        endcase
    end

    // ---------------- input register ----------------
    logic                       in_valid_reg;
    logic signed [SAMPLE_W-1:0] in_x_reg;
    logic                       out_free;
    logic                       advance;

    result_t res_reg;
    logic    res_valid_reg;

    assign out_free = !res_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_x_reg <= $signed(s_tdata[SAMPLE_W-1:0]);
        end
    end

    // ---------------- run state ----------------
    logic signed [SAMPLE_W-1:0] base_reg;
    logic                       have_base_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic signed [DIFF_W-1:0]   min_val_reg;
    logic signed [DIFF_W-1:0]   max_val_reg;
    logic [INDEX_W-1:0]         min_idx_reg;
    logic [INDEX_W-1:0]         max_idx_reg;

    logic signed [DIFF_W-1:0]   diff;
    logic signed [DIFF_W:0]     diff_x;
    logic signed [DIFF_W:0]     thr_pos;
    logic signed [DIFF_W:0]     thr_neg;
    logic                       out_band;
    logic                       upd_min;
    logic                       upd_max;
    logic [CNT_W-1:0]           cnt_next;
    logic [WINDOW_W-1:0]        eff_window;
    logic                       run_done;
    logic signed [DIFF_W-1:0]   min_val_next;
    logic signed [DIFF_W-1:0]   max_val_next;
    logic [INDEX_W-1:0]         min_idx_next;
    logic [INDEX_W-1:0]         max_idx_next;
    result_t                    res_next;

    always_comb begin
        diff     = DIFF_W'(in_x_reg) - DIFF_W'(base_reg);
        diff_x   = (DIFF_W+1)'(diff);
        thr_pos  = $signed({2'b00, threshold_reg});
        thr_neg  = -thr_pos;
        out_band = (diff_x > thr_pos) || (diff_x < thr_neg);
        upd_min  = out_band && (diff < min_val_reg);
        upd_max  = out_band && !upd_min && (diff > max_val_reg);

        min_val_next = upd_min ? diff : min_val_reg;
        max_val_next = upd_max ? diff : max_val_reg;
        min_idx_next = upd_min ? INDEX_W'(cnt_reg) : min_idx_reg;
        max_idx_next = upd_max ? INDEX_W'(cnt_reg) : max_idx_reg;

        cnt_next = cnt_reg + 1'b1;
        if (window_reg == '0) begin
            eff_window = WINDOW_W'(1);
        end else if (window_reg > EFF_MAX_W) begin
            eff_window = EFF_MAX_W;
        end else begin
            eff_window = window_reg;
        end
        run_done = have_base_reg && (WINDOW_W'(cnt_next) >= eff_window);

        if ((min_idx_next == NO_INDEX) && (max_idx_next == NO_INDEX)) begin
            res_next.direction  = DIR_STANDING;
            res_next.category   = CAT_STANDING;
            res_next.peak_value = '0;
        end else if (min_idx_next < max_idx_next) begin
            res_next.direction  = DIR_FORWARD;
            res_next.category   = CAT_FORWARD;
            res_next.peak_value = min_val_next;
        end else begin
            res_next.direction  = DIR_BACKWARD;
            res_next.category   = CAT_BACKWARD;
            res_next.peak_value = max_val_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_base_reg <= 1'b0;
            cnt_reg       <= '0;
            min_val_reg   <= '0;
            max_val_reg   <= '0;
            min_idx_reg   <= NO_INDEX;
            max_idx_reg   <= NO_INDEX;
        end else if (advance) begin
            if (!have_base_reg || run_done) begin
                // start a fresh run: baseline sample or end of window
                have_base_reg <= !have_base_reg;
                cnt_reg       <= '0;
                min_val_reg   <= '0;
                max_val_reg   <= '0;
                min_idx_reg   <= NO_INDEX;
                max_idx_reg   <= NO_INDEX;
            end else begin
                cnt_reg     <= cnt_next;
                min_val_reg <= min_val_next;
                max_val_reg <= max_val_next;
                min_idx_reg <= min_idx_next;
                max_idx_reg <= max_idx_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && !have_base_reg) begin
            base_reg <= in_x_reg;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (out_free) begin
            res_valid_reg <= advance && run_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && run_done) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-$bits(result_t)){1'b0}}, res_reg};

    // ---------------- assertions ----------------
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(cnt_reg) < EFF_MAX)
        else $error("sample count ran past the window limit");

    a_no_peak_before_base: assert property (@(posedge aclk) disable iff (!aresetn)
        !have_base_reg |-> (min_idx_reg == NO_INDEX) && (max_idx_reg == NO_INDEX))
        else $error("peak recorded while waiting for a baseline");

    a_standing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg && (res_reg.direction == DIR_STANDING)
            |-> (res_reg.peak_value == '0) && (res_reg.category == CAT_STANDING))
        else $error("standing result carries a peak");

    a_forward_neg: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg && (res_reg.direction == DIR_FORWARD) |-> res_reg.peak_value < 0)
        else $error("forward result with non-negative peak");

    a_backward_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg && (res_reg.direction == DIR_BACKWARD) |-> res_reg.peak_value > 0)
        else $error("backward result with non-positive peak");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && run_done |=> res_valid_reg)
        else $error("finished run produced no result item");

endmodule

// File: tb/accel_swing_direction_classifier_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// accel_swing_direction_classifier_test
// Self-checking bench for the swing direction classifier.
// ----------------------------------------------------------------------------
// Drives runs of X acceleration samples on the s_ stream, mirrors the
// baseline, peak and position tracking in a predictor and checks every
// result item on the m_ stream in order. A short table covers the dead band
// edges, the full-scale differences, window zero and a window change in
// mid-run; random runs follow under four idling profiles on both streams,
// with register writes between runs and now and then inside one.
// ----------------------------------------------------------------------------
module accel_swing_direction_classifier_test;
    import asdc_pkg::*;

    localparam int DRAIN_CYCLES  = 4;
    localparam int QUIET_LIMIT   = 5000;
    localparam int PHASE_ITEMS   = 215;
    localparam int REPORT_LIMIT  = 10;

    typedef enum {ROW_WRITE, ROW_SAMPLE} row_kind_t;
    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        row_kind_t   kind;
        logic        reg_sel;
        logic [31:0] value;
        bit          typed;
        result_t     want;
    } row_t;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // [15:0] accel_x
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // [1:0] direction, [9:2] category,
                                             // [26:10] peak_value, [31:27] zero

    accel_swing_direction_classifier dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Predictor state
    logic [THRESH_W-1:0]      thr_cfg;
    logic [WINDOW_W-1:0]      win_cfg;
    logic signed [SAMPLE_W-1:0] base_x;
    bit                       base_valid;
    int                       run_count;
    int                       lo_peak;
    int                       hi_peak;
    logic [INDEX_W-1:0]       lo_pos;
    logic [INDEX_W-1:0]       hi_pos;

    result_t    pending_swings[$];
    row_t       plan[$];
    int         sent_items;
    int         mismatches;
    int         quiet_cycles;
    int         send_pct;
    int         stall_pct;
    result_t    seen_swing;
    result_t    want_swing;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function void clear_run();
        run_count = 0;
        lo_peak   = 0;
        hi_peak   = 0;
        lo_pos    = NO_INDEX;
        hi_pos    = NO_INDEX;
    endfunction

    // Advance the predictor by one sample; return 1 when the run closes.
    function bit predict_swing(input logic signed [SAMPLE_W-1:0] x, output result_t r);
        int d;
        int thr;
        int span;
        r = '0;
        if (!base_valid) begin
            base_x     = x;
            base_valid = 1'b1;
            clear_run();
            return 1'b0;
        end
        d   = int'(x) - int'(base_x);
        thr = int'(thr_cfg);
        if (d > thr || d < -thr) begin
            if (d < lo_peak) begin
                lo_peak = d;
                lo_pos  = run_count[INDEX_W-1:0];
            end else if (d > hi_peak) begin
                hi_peak = d;
                hi_pos  = run_count[INDEX_W-1:0];
            end
        end
        run_count++;
        span = (win_cfg == 0) ? 1 : int'(win_cfg);
        if (span > MAX_WINDOW_DEF)
            span = MAX_WINDOW_DEF;
        if (run_count < span)
            return 1'b0;
        if (lo_pos == NO_INDEX && hi_pos == NO_INDEX) begin
            r.direction  = DIR_STANDING;
            r.category   = CAT_STANDING;
            r.peak_value = '0;
        end else if (lo_pos < hi_pos) begin
            r.direction  = DIR_FORWARD;
            r.category   = CAT_FORWARD;
            r.peak_value = lo_peak[DIFF_W-1:0];
        end else begin
            r.direction  = DIR_BACKWARD;
            r.category   = CAT_BACKWARD;
            r.peak_value = hi_peak[DIFF_W-1:0];
        end
        base_valid = 1'b0;
        clear_run();
        return 1'b1;
    endfunction

    function automatic row_t cfg_row(input logic sel, input int v);
        row_t r;
        r         = '{kind: ROW_WRITE, default: '0};
        r.reg_sel = sel;
        r.value   = v;
        return r;
    endfunction

    function automatic row_t sample_row(input int x);
        row_t r;
        r       = '{kind: ROW_SAMPLE, default: '0};
        r.value = x;
        return r;
    endfunction

    function automatic row_t checked_row(input int x, input logic [DIR_W-1:0] dir,
                                         input logic signed [CAT_W-1:0] cat, input int peak);
        row_t r;
        r                 = sample_row(x);
        r.typed           = 1'b1;
        r.want.direction  = dir;
        r.want.category   = cat;
        r.want.peak_value = peak[DIFF_W-1:0];
        return r;
    endfunction

    task set_idling(input idle_mode_t m);
        send_pct  = (m == IDLE_SENDER)   ? 49 : (m == IDLE_BOTH) ? 23 : 0;
        stall_pct = (m == IDLE_RECEIVER) ? 49 : (m == IDLE_BOTH) ? 23 : 0;
    endtask

    task apb_write(input logic sel, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (sel == REG_THRESHOLD)
            thr_cfg = v[THRESH_W-1:0];
        else
            win_cfg = v[WINDOW_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Hold the stream until every expected result is out and the pipe is empty.
    task settle();
        s_tvalid <= 1'b0;
        while (pending_swings.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task pace();
        while ($urandom_range(0, 99) < send_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task send_sample(input logic [15:0] x, input bit typed, input result_t want,
                     output bit ended);
        result_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        do @(posedge aclk); while (!s_tready);
        sent_items++;
        ended = predict_swing(x, r);
        if (ended)
            pending_swings.push_back(typed ? want : r);
    endtask

    function automatic logic [15:0] pick_sample(input logic signed [15:0] base);
        int span;
        int off;
        int v;
        int mode;
        logic [31:0] raw;
        span = int'(thr_cfg) * 2 + 64;
        mode = $urandom_range(0, 9);
        if (mode < 7) begin
            off = int'($urandom_range(0, span * 2)) - span;
        end else if (mode < 9) begin
            raw = $urandom;
            return raw[15:0];
        end else begin
            off = $urandom_range(0, 1) ? int'(thr_cfg) : -int'(thr_cfg);
        end
        v = int'(base) + off;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    task new_setting(input bit long_run);
        int pick;
        logic [31:0] thr;
        logic [31:0] win;
        settle();
        pick = $urandom_range(0, 9);
        case (pick)
            0:       thr = 0;
            1:       thr = 65535;
            2:       thr = 4915;
            3:       thr = $urandom_range(0, 65535);
            default: thr = $urandom_range(0, 3000);
        endcase
        pick = $urandom_range(0, 9);
        case (pick)
            0:       win = 0;
            1:       win = 1;
            8:       win = $urandom_range(13, 40);
            9:       win = 75;
            default: win = $urandom_range(2, 12);
        endcase
        if (long_run)
            win = 255;
        apb_write(REG_THRESHOLD, thr);
        apb_write(REG_WINDOW, win);
    endtask

    task swing_run();
        logic [15:0] base;
        logic [31:0] raw;
        bit          ended;
        int          k;
        int          cut;
        raw  = $urandom;
        base = $urandom_range(0, 1) ? raw[15:0] : 16'($urandom_range(0, 4000) - 2000);
        cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 0;
        pace();
        send_sample(base, 1'b0, '0, ended);
        k     = 0;
        ended = 1'b0;
        while (!ended) begin
            // shift the window under a run in progress
            if (cut != 0 && k == cut) begin
                settle();
                apb_write(REG_WINDOW, $urandom_range(0, 12));
            end
            pace();
            send_sample(pick_sample(base), 1'b0, '0, ended);
            k++;
        end
    endtask

    task note_mismatch(input string what, input result_t want, input result_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%s: expected dir=%0d cat=%0d peak=%0d, got dir=%0d cat=%0d peak=%0d pad=%0h",
                     what, want.direction, want.category, want.peak_value,
                     got.direction, got.category, got.peak_value,
                     m_tdata[OUT_TDATA_W-1:$bits(result_t)]);
    endtask

    always @(posedge aclk) begin
        m_tready <= aresetn && ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_swing = m_tdata[$bits(result_t)-1:0];
            if (pending_swings.size() == 0) begin
                note_mismatch("unexpected item", '0, seen_swing);
            end else begin
                want_swing = pending_swings.pop_front();
                if (seen_swing.direction != want_swing.direction
                    || seen_swing.category != want_swing.category
                    || seen_swing.peak_value != want_swing.peak_value
                    || m_tdata[OUT_TDATA_W-1:$bits(result_t)] != '0)
                    note_mismatch("field", want_swing, seen_swing);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        bit ended;
        sent_items   = 0;
        thr_cfg      = THRESHOLD_RST;
        win_cfg      = WINDOW_RST;
        base_x       = '0;
        base_valid   = 1'b0;
        clear_run();
        set_idling(IDLE_NONE);

        // dead band edge: both +/- threshold are ignored
        plan.push_back(cfg_row(REG_THRESHOLD, 100));
        plan.push_back(cfg_row(REG_WINDOW, 3));
        plan.push_back(sample_row(0));
        plan.push_back(sample_row(100));
        plan.push_back(sample_row(-100));
        plan.push_back(checked_row(0, DIR_STANDING, CAT_STANDING, 0));
        // minimum first, then maximum first
        plan.push_back(sample_row(0));
        plan.push_back(sample_row(-200));
        plan.push_back(sample_row(300));
        plan.push_back(sample_row(50));
        plan.push_back(sample_row(0));
        plan.push_back(sample_row(300));
        plan.push_back(sample_row(-200));
        plan.push_back(sample_row(0));
        // full-scale differences with no dead band, then with the widest one
        plan.push_back(cfg_row(REG_THRESHOLD, 0));
        plan.push_back(cfg_row(REG_WINDOW, 1));
        plan.push_back(sample_row(-32768));
        plan.push_back(checked_row(32767, DIR_BACKWARD, CAT_BACKWARD, 65535));
        plan.push_back(sample_row(32767));
        plan.push_back(checked_row(-32768, DIR_FORWARD, CAT_FORWARD, -65535));
        plan.push_back(sample_row(5));
        plan.push_back(checked_row(5, DIR_STANDING, CAT_STANDING, 0));
        plan.push_back(cfg_row(REG_THRESHOLD, 65535));
        plan.push_back(sample_row(-32768));
        plan.push_back(checked_row(32767, DIR_STANDING, CAT_STANDING, 0));
        // window zero behaves as one
        plan.push_back(cfg_row(REG_THRESHOLD, 0));
        plan.push_back(cfg_row(REG_WINDOW, 0));
        plan.push_back(sample_row(0));
        plan.push_back(sample_row(1));
        // shrink the window below the samples already taken
        plan.push_back(cfg_row(REG_WINDOW, 10));
        plan.push_back(sample_row(0));
        plan.push_back(sample_row(-5));
        plan.push_back(sample_row(7));
        plan.push_back(sample_row(3));
        plan.push_back(cfg_row(REG_WINDOW, 2));
        plan.push_back(sample_row(9));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                settle();
                apb_write(plan[i].reg_sel, plan[i].value);
            end else begin
                send_sample(plan[i].value[15:0], plan[i].typed, plan[i].want, ended);
            end
        end

        for (int m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
            set_idling(idle_mode_t'(m));
            new_setting(m == IDLE_RECEIVER);
            for (int goal = sent_items + PHASE_ITEMS; sent_items < goal; ) begin
                if ($urandom_range(0, 3) == 0)
                    new_setting(1'b0);
                swing_run();
            end
        end

        // every run is closed here; drain the last results
        s_tvalid <= 1'b0;
        while (pending_swings.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES * 2) @(posedge aclk);
        if (mismatches == 0 && pending_swings.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
